>>> hdl/bra_pkg.sv
// Shared types and constants of the bitmap run allocator.
`timescale 1ns / 1ps

package bra_pkg;

    localparam int WORD_W = 8;
    localparam logic [WORD_W-1:0] WORD_ONES = 8'hFF;
    localparam int LEN_W  = 11;
    localparam int IDX_W  = 10;
    localparam int KIND_W = 2;

    localparam logic [KIND_W-1:0] KIND_FILL  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TEST  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic load;       // latch command fields and managed limit
        logic fill_wr;    // write a whole word, step the word address
        logic clear;      // fill with zeros (clearing pass)
        logic bounds;     // compute end of the write range
        logic rng_init;   // word address to first word of the range
        logic rng_rd;     // read word for merge
        logic rng_wr;     // write merged word, step the word address
        logic test_rd;    // read word holding the tested bit
        logic test_cap;   // capture the tested bit
        logic scan_step;  // one word of the run search
    } t_dp_ctl;

    // datapath -> controller
    typedef struct packed {
        logic fill_last;
        logic rng_empty;
        logic rng_last;
        logic scan_hit;
        logic scan_miss;
    } t_dp_sts;

endpackage

>>> hdl/bitmap_run_allocator_core.sv
// Bitmap run allocator: fill, range set, bit test, first-fit run search and inversion.
// Usage: a command (kind, start_index, run_length, value) transfers at a rising
// edge with start high and busy low; busy stays high until its result is out.
// Every command gives one result, on o_bit_value / o_alloc_ok / o_alloc_start
// for exactly one cycle with o_strobe high; the receiver cannot stall it.
// bits_in_use transfers on the cfg channel (i_cfg_valid / o_cfg_ready, always
// ready); the user must write it only between commands; the block does not enforce it.
// The store is a byte-wide single-port memory of W = ceil(NBITS/8) words.
// Steps from the accepting edge to the strobe cycle:
//   fill all:     one word written per cycle
//   set range:    read-modify-write per touched word
//   test bit:     read of the word holding the bit, then capture of the bit
//   allocate:     the scan reads one word per cycle; a found run is then
//                 inverted by read-modify-write per word of the run.
// busy falls in the cycle after the strobe, then the next command is taken.
// Reset: synchronous, active low; afterwards a clearing pass writes zeros to
// all W words (busy high) before the first command is accepted.
`timescale 1ns / 1ps

module bitmap_run_allocator_core
    import bra_pkg::*;
#(
    parameter int NBITS = 1024
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [IDX_W-1:0]  i_start_index,
    input  logic [LEN_W-1:0]  i_run_length,
    input  logic              i_value,
    output logic              o_strobe,
    output logic              o_bit_value,
    output logic              o_alloc_ok,
    output logic [IDX_W-1:0]  o_alloc_start,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [LEN_W-1:0]  i_cfg_data
);

    logic [LEN_W-1:0] r_bits_in_use;
    t_dp_ctl          ctl;
    t_dp_sts          sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits_in_use <= 11'd1024;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_bits_in_use <= i_cfg_data;
        end
    end

    bra_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_kind   (i_kind),
        .i_sts    (sts),
        .o_ctl    (ctl),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    bra_dp #(
        .NBITS (NBITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .i_bits_in_use  (r_bits_in_use),
        .i_start_index  (i_start_index),
        .i_run_length   (i_run_length),
        .i_value        (i_value),
        .o_bit_value    (o_bit_value),
        .o_alloc_ok     (o_alloc_ok),
        .o_alloc_start  (o_alloc_start)
    );

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe outside a command");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");

    a_fail_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_alloc_ok) |-> (o_alloc_start == '0))
        else $error("nonzero start without a found run");

endmodule

>>> hdl/bra_ctrl.sv
// Command sequencer of the bitmap run allocator.
`timescale 1ns / 1ps

module bra_ctrl
    import bra_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [KIND_W-1:0] i_kind,
    input  t_dp_sts           i_sts,
    output t_dp_ctl           o_ctl,
    output logic              o_busy,
    output logic              o_strobe
);

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_FILL    = 4'd2;
    localparam logic [3:0] S_BOUNDS  = 4'd3;
    localparam logic [3:0] S_RNG_CHK = 4'd4;
    localparam logic [3:0] S_RNG_RD  = 4'd5;
    localparam logic [3:0] S_RNG_WR  = 4'd6;
    localparam logic [3:0] S_TST_RD  = 4'd7;
    localparam logic [3:0] S_TST_CAP = 4'd8;
    localparam logic [3:0] S_SCAN    = 4'd9;
    localparam logic [3:0] S_RESP    = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_INIT: begin
                o_ctl.fill_wr = 1'b1;
                o_ctl.clear   = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    case (i_kind)
                        KIND_FILL: n_state = S_FILL;
                        KIND_SET:  n_state = S_BOUNDS;
                        KIND_TEST: n_state = S_TST_RD;
                        default:   n_state = S_SCAN;
                    endcase
                end
            end
            S_FILL: begin
                o_ctl.fill_wr = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = S_RESP;
                end
            end
            S_BOUNDS: begin
                o_ctl.bounds = 1'b1;
                n_state      = S_RNG_CHK;
            end
            S_RNG_CHK: begin
                o_ctl.rng_init = 1'b1;
                n_state        = i_sts.rng_empty ? S_RESP : S_RNG_RD;
            end
            S_RNG_RD: begin
                o_ctl.rng_rd = 1'b1;
                n_state      = S_RNG_WR;
            end
            S_RNG_WR: begin
                o_ctl.rng_wr = 1'b1;
                n_state      = i_sts.rng_last ? S_RESP : S_RNG_RD;
            end
            S_TST_RD: begin
                o_ctl.test_rd = 1'b1;
                n_state       = S_TST_CAP;
            end
            S_TST_CAP: begin
                o_ctl.test_cap = 1'b1;
                n_state        = S_RESP;
            end
            S_SCAN: begin
                o_ctl.scan_step = 1'b1;
                // a found run is inverted through the range write path
                if (i_sts.scan_hit) begin
                    n_state = S_BOUNDS;
                end else if (i_sts.scan_miss) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_RESP);

endmodule

>>> hdl/bra_dp.sv
// Datapath of the bitmap run allocator: word store, range merge and run search.
`timescale 1ns / 1ps

module bra_dp
    import bra_pkg::*;
#(
    parameter int NBITS = 1024
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_ctl          i_ctl,
    output t_dp_sts          o_sts,
    input  logic [LEN_W-1:0] i_bits_in_use,
    input  logic [IDX_W-1:0] i_start_index,
    input  logic [LEN_W-1:0] i_run_length,
    input  logic             i_value,
    output logic             o_bit_value,
    output logic             o_alloc_ok,
    output logic [IDX_W-1:0] o_alloc_start
);

    localparam int NWORDS = (NBITS + WORD_W - 1) / WORD_W;
    localparam int WAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int AAW    = WAW + 1;
    localparam int CW     = $clog2(NBITS + 1);
    localparam int EW     = ((CW > 12) ? CW : 12) + 1;

    logic [WORD_W-1:0] r_mem [NWORDS];
    logic [WORD_W-1:0] r_rdata;

    logic [EW-1:0]    r_lo,      n_lo;
    logic [EW-1:0]    r_end,     n_end;
    logic [EW-1:0]    r_lim,     n_lim;
    logic [LEN_W-1:0] r_len,     n_len;
    logic [LEN_W-1:0] r_run,     n_run;
    logic             r_val,     n_val;
    logic [AAW-1:0]   r_addr,    n_addr;
    logic [AAW-1:0]   r_ev_word, n_ev_word;
    logic             r_ev_vld,  n_ev_vld;
    logic             r_bit,     n_bit;
    logic             r_ok,      n_ok;

    logic [EW-1:0]     lim_in;
    logic [EW-1:0]     sum_end;
    logic [EW-1:0]     bnd;
    logic [EW-1:0]     end_m1;
    logic [EW-1:0]     lim_m1;
    logic [EW-1:0]     where;
    logic [AAW-1:0]    lo_word;
    logic [AAW-1:0]    hi_word;
    logic [AAW-1:0]    last_word;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] merged;
    logic [WORD_W-1:0] m;
    logic [WORD_W-1:0] hit_v;
    logic [2:0]        bsel;
    logic [LEN_W-1:0]  run_next;
    logic              fail_now;
    logic              issue;
    logic              hit;
    logic              miss;
    logic              tst_in;
    logic              rd_en;
    logic [AAW-1:0]    rd_addr;
    logic              wr_en;
    logic [WORD_W-1:0] wr_data;

    // managed bits saturate at the store size
    assign lim_in  = (EW'(i_bits_in_use) > EW'(NBITS)) ? EW'(NBITS) : EW'(i_bits_in_use);
    assign sum_end = r_lo + EW'(r_len);
    assign bnd     = (sum_end < r_lim) ? sum_end : r_lim;
    assign end_m1  = r_end - EW'(1);
    assign lim_m1  = r_lim - EW'(1);

    assign lo_word   = AAW'(r_lo[WAW+2:3]);
    assign hi_word   = AAW'(end_m1[WAW+2:3]);
    assign last_word = AAW'(lim_m1[WAW+2:3]);

    assign tst_in   = (r_lo < EW'(NBITS));
    assign fail_now = (r_len == '0) || (r_lim == '0);
    assign issue    = !fail_now && (r_addr <= last_word);

    // range write mask for the word at r_addr
    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            mask[b] = (EW'({r_addr, 3'(b)}) >= r_lo) && (EW'({r_addr, 3'(b)}) < r_end);
        end
    end

    assign merged = (r_rdata & ~mask) | (r_val ? mask : '0);

    // matching bits of the evaluated word, cut at the managed limit
    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            m[b] = (r_rdata[b] == r_val) && (EW'({r_ev_word, 3'(b)}) < r_lim);
        end
    end

    // run length ending at each bit: carried run if the word is all match so far,
    // else the local run inside the word
    always_comb begin : scan_eval
        logic             full;
        logic [3:0]       lrun;
        logic [LEN_W:0]   tot;
        full     = 1'b1;
        hit_v    = '0;
        run_next = '0;
        bsel     = '0;
        for (int b = 0; b < WORD_W; b++) begin
            full = full & m[b];
            lrun = '0;
            for (int k = 0; k < WORD_W; k++) begin
                if ((k <= b) && m[3'(b - k)] && (lrun == 4'(k))) begin
                    lrun = 4'(k + 1);
                end
            end
            tot = full ? ((LEN_W + 1)'(r_run) + (LEN_W + 1)'(b + 1)) : (LEN_W + 1)'(lrun);
            hit_v[b] = (tot == (LEN_W + 1)'(r_len));
            if (b == WORD_W - 1) begin
                run_next = tot[LEN_W-1:0];
            end
        end
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (hit_v[b]) begin
                bsel = 3'(b);
            end
        end
    end

    assign where = EW'({r_ev_word, bsel}) + EW'(1) - EW'(r_len);
    assign hit   = r_ev_vld && !fail_now && (|hit_v);
    assign miss  = fail_now || (r_ev_vld && (r_ev_word == last_word) && !(|hit_v));

    assign o_sts.fill_last = (r_addr == AAW'(NWORDS - 1));
    assign o_sts.rng_empty = (r_lo >= r_end);
    assign o_sts.rng_last  = (r_addr == hi_word);
    assign o_sts.scan_hit  = i_ctl.scan_step && hit;
    assign o_sts.scan_miss = i_ctl.scan_step && miss;

    // store port select
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_addr;
        wr_en   = 1'b0;
        wr_data = merged;
        if (i_ctl.rng_rd) begin
            rd_en = 1'b1;
        end
        if (i_ctl.scan_step) begin
            rd_en = issue;
        end
        if (i_ctl.test_rd) begin
            rd_en   = tst_in;
            rd_addr = lo_word;
        end
        if (i_ctl.rng_wr) begin
            wr_en = 1'b1;
        end
        if (i_ctl.fill_wr) begin
            wr_en   = 1'b1;
            wr_data = (i_ctl.clear || !r_val) ? '0 : WORD_ONES;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && (r_addr < AAW'(NWORDS))) begin
            r_mem[r_addr[WAW-1:0]] <= wr_data;
        end
        if (rd_en && (rd_addr < AAW'(NWORDS))) begin
            r_rdata <= r_mem[rd_addr[WAW-1:0]];
        end
    end

    always_comb begin
        n_lo      = r_lo;
        n_end     = r_end;
        n_lim     = r_lim;
        n_len     = r_len;
        n_run     = r_run;
        n_val     = r_val;
        n_addr    = r_addr;
        n_ev_word = r_ev_word;
        n_ev_vld  = r_ev_vld;
        n_bit     = r_bit;
        n_ok      = r_ok;
        if (i_ctl.load) begin
            n_lo     = EW'(i_start_index);
            n_len    = i_run_length;
            n_val    = i_value;
            n_lim    = lim_in;
            n_addr   = '0;
            n_ev_vld = 1'b0;
            n_run    = '0;
            n_bit    = 1'b0;
            n_ok     = 1'b0;
        end
        if (i_ctl.fill_wr || i_ctl.rng_wr) begin
            n_addr = r_addr + AAW'(1);
        end
        if (i_ctl.bounds) begin
            n_end = bnd;
        end
        if (i_ctl.rng_init) begin
            n_addr = lo_word;
        end
        if (i_ctl.test_cap) begin
            n_bit = tst_in && r_rdata[r_lo[2:0]];
        end
        if (i_ctl.scan_step) begin
            n_ev_vld  = issue;
            n_ev_word = r_addr;
            if (issue) begin
                n_addr = r_addr + AAW'(1);
            end
            if (r_ev_vld) begin
                n_run = run_next;
            end
            if (hit) begin
                // found run becomes the range to invert
                n_lo  = where;
                n_val = ~r_val;
                n_ok  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_ev_vld <= 1'b0;
        end else begin
            r_addr   <= n_addr;
            r_ev_vld <= n_ev_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo      <= n_lo;
        r_end     <= n_end;
        r_lim     <= n_lim;
        r_len     <= n_len;
        r_run     <= n_run;
        r_val     <= n_val;
        r_ev_word <= n_ev_word;
        r_bit     <= n_bit;
        r_ok      <= n_ok;
    end

    assign o_bit_value   = r_bit;
    assign o_alloc_ok    = r_ok;
    assign o_alloc_start = r_ok ? r_lo[IDX_W-1:0] : '0;

endmodule

>>> tb/bra_checker.sv
// Result checker for the bitmap run allocator: mirrors the bit store and compares every result.
`timescale 1ns / 1ps

module bra_checker
    import bra_pkg::*;
#(
    parameter int NBITS = 1024
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [IDX_W-1:0]  i_start_index,
    input  logic [LEN_W-1:0]  i_run_length,
    input  logic              i_value,
    input  logic              i_strobe,
    input  logic              i_bit_value,
    input  logic              i_alloc_ok,
    input  logic [IDX_W-1:0]  i_alloc_start,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [LEN_W-1:0]  i_cfg_data,
    output int                o_errors,
    output int                o_pending
);

    typedef struct packed {
        logic             bit_value;
        logic             alloc_ok;
        logic [IDX_W-1:0] alloc_start;
    } t_answer;

    bit [NBITS-1:0]   bitmap;
    logic [LEN_W-1:0] bits_in_use;
    t_answer          answers_q[$];
    int               errors = 0;

    assign o_errors = errors;

    // bits_in_use above the store size saturates
    function automatic int managed_limit();
        return (bits_in_use > NBITS) ? NBITS : int'(bits_in_use);
    endfunction

    function automatic void paint_run(input int first, input int len, input bit v);
        int lim;
        lim = managed_limit();
        for (int k = 0; k < len && first + k < lim; k++) begin
            bitmap[first + k] = v;
        end
    endfunction

    // Applies one command to the mirrored store and returns its result.
    function automatic t_answer apply_command(input logic [KIND_W-1:0] kind, input int idx,
                                              input int len, input bit v);
        t_answer a;
        int      run;
        int      lim;
        a   = '0;
        run = 0;
        lim = managed_limit();
        case (kind)
            KIND_FILL: begin
                bitmap = {NBITS{v}};
            end
            KIND_SET: begin
                paint_run(idx, len, v);
            end
            KIND_TEST: begin
                if (idx < NBITS) a.bit_value = bitmap[idx];
            end
            KIND_ALLOC: begin
                // first fit: lowest start of len matching bits inside the managed range
                if (len != 0) begin
                    for (int i = 0; i < lim; i++) begin
                        run = (bitmap[i] == v) ? run + 1 : 0;
                        if (run == len) begin
                            a.alloc_ok    = 1'b1;
                            a.alloc_start = IDX_W'(i + 1 - len);
                            break;
                        end
                    end
                    if (a.alloc_ok) paint_run(int'(a.alloc_start), len, !v);
                end
            end
            default: begin
            end
        endcase
        return a;
    endfunction

    always @(posedge i_clk) begin : watch
        t_answer got;
        t_answer want;
        if (!i_rst_n) begin
            bitmap      = '0;
            bits_in_use = LEN_W'(NBITS);
            answers_q.delete();
        end else begin
            if (i_strobe) begin
                got.bit_value   = i_bit_value;
                got.alloc_ok    = i_alloc_ok;
                got.alloc_start = i_alloc_start;
                if (answers_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result %0d/%0d/%0d",
                                 got.bit_value, got.alloc_ok, got.alloc_start);
                end else begin
                    want = answers_q.pop_front();
                    if (got.bit_value !== want.bit_value || got.alloc_ok !== want.alloc_ok ||
                        got.alloc_start !== want.alloc_start) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     want.bit_value, want.alloc_ok, want.alloc_start,
                                     got.bit_value, got.alloc_ok, got.alloc_start);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) bits_in_use = i_cfg_data;
            if (i_start && !i_busy)
                answers_q.push_back(apply_command(i_kind, int'(i_start_index),
                                                  int'(i_run_length), i_value));
        end
        o_pending = answers_q.size();
    end

endmodule

>>> tb/tb_bitmap_run_allocator_core.sv
// Testbench top for the bitmap run allocator: command stimulus, register writes and verdict.
`timescale 1ns / 1ps

module tb_bitmap_run_allocator_core;
    import bra_pkg::*;

    localparam int NBITS       = 1024;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int PHASE_ITEMS = 200;
    localparam int NUM_PHASES  = 8;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [KIND_W-1:0] i_kind = '0;
    logic [IDX_W-1:0]  i_start_index = '0;
    logic [LEN_W-1:0]  i_run_length = '0;
    logic              i_value = 1'b0;
    logic              o_strobe;
    logic              o_bit_value;
    logic              o_alloc_ok;
    logic [IDX_W-1:0]  o_alloc_start;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [LEN_W-1:0]  i_cfg_data = '0;

    int errors;
    int pending;
    int cycles = 0;
    bit gaps_on = 1'b1;
    int cur_lim = NBITS;
    int phase_cfg[NUM_PHASES];

    bitmap_run_allocator_core #(.NBITS(NBITS)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_start_index (i_start_index),
        .i_run_length  (i_run_length),
        .i_value       (i_value),
        .o_strobe      (o_strobe),
        .o_bit_value   (o_bit_value),
        .o_alloc_ok    (o_alloc_ok),
        .o_alloc_start (o_alloc_start),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    bra_checker #(.NBITS(NBITS)) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_kind        (i_kind),
        .i_start_index (i_start_index),
        .i_run_length  (i_run_length),
        .i_value       (i_value),
        .i_strobe      (o_strobe),
        .i_bit_value   (o_bit_value),
        .i_alloc_ok    (o_alloc_ok),
        .i_alloc_start (o_alloc_start),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Holds the command until it transfers; start drops at random while gaps are on.
    task automatic issue(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
                         input logic [LEN_W-1:0] len, input logic v);
        bit taken;
        bit offered;
        taken = 1'b0;
        while (!taken) begin
            if (gaps_on && $urandom_range(99) < 31) begin
                start   <= 1'b0;
                offered = 1'b0;
            end else begin
                start         <= 1'b1;
                i_kind        <= kind;
                i_start_index <= idx;
                i_run_length  <= len;
                i_value       <= v;
                offered       = 1'b1;
            end
            @(posedge i_clk);
            taken = offered && (busy === 1'b0);
        end
    endtask

    // Register write only once the block is idle and every result is in.
    task automatic write_bits_in_use(input logic [LEN_W-1:0] n);
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0 || busy !== 1'b0);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= n;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        cur_lim = (n > NBITS) ? NBITS : int'(n);
    endtask

    task automatic random_command();
        logic [KIND_W-1:0] kind;
        int                pick;
        int                idx;
        int                len;
        pick = $urandom_range(99);
        if (pick < 5) kind = KIND_FILL;
        else if (pick < 35) kind = KIND_SET;
        else if (pick < 55) kind = KIND_TEST;
        else kind = KIND_ALLOC;
        // half the indexes aimed at the managed range
        if ($urandom_range(1) == 1 && cur_lim > 0) idx = $urandom_range(cur_lim - 1);
        else idx = $urandom_range(NBITS - 1);
        pick = $urandom_range(99);
        if (pick < 2) len = 0;
        else if (pick < 70) len = $urandom_range(8, 1);
        else if (pick < 90) len = $urandom_range(64, 9);
        else if (pick < 97) len = $urandom_range(1023, 65);
        else len = $urandom_range(2047, 1024);
        issue(kind, IDX_W'(idx), LEN_W'(len), 1'($urandom_range(1)));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full store: fills, whole-store runs, clipped and empty writes
        write_bits_in_use(11'd1024);
        issue(KIND_TEST, 10'd0, 11'd0, 1'b0);
        issue(KIND_TEST, 10'd1023, 11'd0, 1'b0);
        issue(KIND_FILL, 10'd0, 11'd0, 1'b1);
        issue(KIND_TEST, 10'd1023, 11'd0, 1'b0);
        issue(KIND_ALLOC, 10'd0, 11'd1, 1'b1);
        issue(KIND_ALLOC, 10'd0, 11'd0, 1'b1);
        issue(KIND_ALLOC, 10'd0, 11'd1024, 1'b1);
        issue(KIND_FILL, 10'd0, 11'd0, 1'b0);
        issue(KIND_ALLOC, 10'd0, 11'd1024, 1'b0);
        issue(KIND_SET, 10'd1023, 11'd2047, 1'b0);
        issue(KIND_SET, 10'd5, 11'd0, 1'b0);
        issue(KIND_ALLOC, 10'd0, 11'd1, 1'b0);

        // one managed bit: writes past it do nothing, unmanaged bits still read
        write_bits_in_use(11'd1);
        issue(KIND_SET, 10'd1, 11'd5, 1'b0);
        issue(KIND_ALLOC, 10'd0, 11'd1, 1'b1);
        issue(KIND_ALLOC, 10'd0, 11'd2, 1'b0);
        issue(KIND_TEST, 10'd1000, 11'd0, 1'b0);

        // nothing managed: allocate fails, fill and test still act
        write_bits_in_use(11'd0);
        issue(KIND_ALLOC, 10'd0, 11'd1, 1'b0);
        issue(KIND_SET, 10'd0, 11'd1, 1'b1);
        issue(KIND_TEST, 10'd0, 11'd0, 1'b0);
        issue(KIND_FILL, 10'd0, 11'd0, 1'b0);

        // register above the store size saturates
        write_bits_in_use(11'd2047);
        issue(KIND_SET, 10'd1000, 11'd100, 1'b1);
        issue(KIND_ALLOC, 10'd0, 11'd24, 1'b1);
        issue(KIND_ALLOC, 10'd0, 11'd1024, 1'b0);
        issue(KIND_TEST, 10'd1023, 11'd0, 1'b0);

        phase_cfg = '{1024, 64, 1025, 300, 8, 2047, 1024, 513};
        phase_cfg[6] = $urandom_range(1024, 1);
        for (int p = 0; p < NUM_PHASES; p++) begin
            gaps_on = (p != 3);
            write_bits_in_use(LEN_W'(phase_cfg[p]));
            repeat (PHASE_ITEMS) random_command();
        end

        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
